>>> sv/gft_pkg.sv
package gft_pkg;

    // Field widths
    localparam int PROG_W     = 17;
    localparam int STRIDE_W   = 18;
    localparam int OFS_W      = 18;
    localparam int Z_W        = 16;
    localparam int HEIGHT_W   = 16;
    localparam int FRAC_W     = 17;
    localparam int CFG_DATA_W = 17;
    localparam int CFG_IDX_W  = 1;

    // Internal datapath widths
    localparam int UT_W    = 31;  // u*t <= 2^30
    localparam int V_W     = 18;  // t - u, signed
    localparam int KP_W    = 34;  // stride * (0.5 - t), signed
    localparam int D_W     = 50;  // t^3 - u^3, signed
    localparam int P_W     = 48;  // u*t*(t - u), signed
    localparam int ZP_W    = 47;  // apex height * u*t
    localparam int W_W     = 33;  // Q0.32 Bezier weight, signed
    localparam int PIPE_STAGES = 8;

    localparam logic [PROG_W-1:0]   ONE_Q16  = 17'h10000;
    localparam logic [PROG_W-1:0]   HALF_Q16 = 17'h08000;

    localparam logic [HEIGHT_W-1:0]      HEIGHT_RESET   = 16'd3277;
    // control_fraction reset 16384, held as f - 0.5
    localparam logic signed [FRAC_W-1:0] FRAC_OFS_RESET = -17'sd16384;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_APEX_HEIGHT      = 1'b0,
        CFG_CONTROL_FRACTION = 1'b1
    } cfg_index_t;

    // Per-item values that ride along the pipe up to stage 7
    typedef struct packed {
        logic                       swing;
        logic signed [STRIDE_W-1:0] sx;
        logic signed [STRIDE_W-1:0] sy;
    } gft_side_t;

endpackage

>>> sv/gft_query_if.sv
interface gft_query_if;
    logic                                valid;
    logic                                ready;
    logic                                in_swing;
    logic [gft_pkg::PROG_W-1:0]          progress;
    logic signed [gft_pkg::STRIDE_W-1:0] span_x;
    logic signed [gft_pkg::STRIDE_W-1:0] span_y;

    modport source (output valid, in_swing, progress, span_x, span_y, input ready);
    modport sink   (input valid, in_swing, progress, span_x, span_y, output ready);
endinterface

>>> sv/gft_offset_if.sv
interface gft_offset_if;
    logic                             valid;
    logic                             ready;
    logic signed [gft_pkg::OFS_W-1:0] offset_x;
    logic signed [gft_pkg::OFS_W-1:0] offset_y;
    logic [gft_pkg::Z_W-1:0]          offset_z;

    modport source (output valid, offset_x, offset_y, offset_z, input ready);
    modport sink   (input valid, offset_x, offset_y, offset_z, output ready);
endinterface

>>> sv/gait_foot_trajectory.sv
// Swing/stance foot trajectory for one leg, no state between queries. Each
// query transfer (phase flag, progress t in Q1.16, stride x/y in Q1.16) gives
// exactly one offset transfer. Stance slides the foot linearly from +stride/2
// to -stride/2 at zero height; swing follows a cubic Bernstein Bezier from
// -stride/2 to +stride/2 with inner control points at f and 1-f of the
// stride and apex equal to the configured apex height. The datapath is an
// 8-stage pipeline: one query is taken every cycle unless a held output has
// filled every stage; each result moves through the stage registers in order
// and waits in the stage 8 output register until taken. Each stage has its
// own valid bit and loads whenever it is empty or its successor moves, so a
// held output only blocks input once every stage is full. The depth is set
// by the two wide multiplier chains (u*t -> Bernstein terms -> blend ->
// stride scale). The user must write registers through cfg_we / cfg_index /
// cfg_wdata only while no query is in flight; the block does not enforce it.
module gait_foot_trajectory (
    input  logic                              clk,
    input  logic                              rst_n,
    gft_query_if.sink                         query,
    gft_offset_if.source                      offset,
    input  logic                              cfg_we,
    input  logic [gft_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [gft_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

    // ------------------------------------------------------------------
    // Configuration registers. control_fraction is stored already
    // saturated to 1.0 and offset by -0.5 (g = f - 0.5), which is the only
    // form the blend stage uses.
    // ------------------------------------------------------------------
    logic [gft_pkg::HEIGHT_W-1:0]      apex_height_reg;
    logic [gft_pkg::HEIGHT_W-1:0]      apex_height_next;
    logic signed [gft_pkg::FRAC_W-1:0] frac_offset_reg;
    logic signed [gft_pkg::FRAC_W-1:0] frac_offset_next;
    logic [gft_pkg::FRAC_W-1:0]        frac_sat;

    always_comb
    begin
        apex_height_next = apex_height_reg;
        frac_offset_next = frac_offset_reg;
        frac_sat = (cfg_wdata > gft_pkg::ONE_Q16) ? gft_pkg::ONE_Q16 : cfg_wdata;
        if (cfg_we)
        begin
            unique case (gft_pkg::cfg_index_t'(cfg_index))
                gft_pkg::CFG_APEX_HEIGHT:
                begin
                    apex_height_next = cfg_wdata[gft_pkg::HEIGHT_W-1:0];
                end
                gft_pkg::CFG_CONTROL_FRACTION:
                begin
                    // wraps correctly: result lies in [-0.5, +0.5]
                    frac_offset_next = $signed(frac_sat - gft_pkg::HALF_Q16);
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            apex_height_reg <= gft_pkg::HEIGHT_RESET;
            frac_offset_reg <= gft_pkg::FRAC_OFS_RESET;
        end
        else
        begin
            apex_height_reg <= apex_height_next;
            frac_offset_reg <= frac_offset_next;
        end
    end

    // ------------------------------------------------------------------
    // Pipeline flow control: per-stage valid bits, stage load enables.
    // ------------------------------------------------------------------
    logic [gft_pkg::PIPE_STAGES-1:0] stage_en;

    gft_pipe_ctrl #(
        .STAGES (gft_pkg::PIPE_STAGES)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (query.valid),
        .out_ready (offset.ready),
        .in_ready  (query.ready),
        .out_valid (offset.valid),
        .en        (stage_en)
    );

    // ------------------------------------------------------------------
    // Stages 1-2: clamp t, u*t, t-u, Bernstein difference D = t^3 - u^3,
    // P = u*t*(t-u), lift product and the rounded stance offsets.
    // ------------------------------------------------------------------
    gft_pkg::gft_side_t                 side_a;
    logic signed [gft_pkg::D_W-1:0]     dterm;
    logic signed [gft_pkg::P_W-1:0]     pterm;
    logic [gft_pkg::ZP_W-1:0]           zprod;
    logic signed [gft_pkg::OFS_W-1:0]   stance_x_a;
    logic signed [gft_pkg::OFS_W-1:0]   stance_y_a;

    gft_front u_front (
        .clk         (clk),
        .en          (stage_en[1:0]),
        .in_swing    (query.in_swing),
        .progress    (query.progress),
        .span_x      (query.span_x),
        .span_y      (query.span_y),
        .apex_height (apex_height_reg),
        .side        (side_a),
        .dterm       (dterm),
        .pterm       (pterm),
        .zprod       (zprod),
        .stance_x    (stance_x_a),
        .stance_y    (stance_y_a)
    );

    // ------------------------------------------------------------------
    // Stages 3-6: inner control point blend. The middle Bernstein terms
    // reduce to E = -3*P; weight w = round((D + round(g*E/2^15)) / 2^17),
    // a Q0.32 fraction of the stride.
    // ------------------------------------------------------------------
    gft_pkg::gft_side_t                 side_b;
    logic signed [gft_pkg::W_W-1:0]     weight;
    logic [gft_pkg::Z_W-1:0]            lift;
    logic signed [gft_pkg::OFS_W-1:0]   stance_x_b;
    logic signed [gft_pkg::OFS_W-1:0]   stance_y_b;

    gft_weight u_weight (
        .clk          (clk),
        .en           (stage_en[5:2]),
        .frac_offset  (frac_offset_reg),
        .side_in      (side_a),
        .dterm        (dterm),
        .pterm        (pterm),
        .zprod        (zprod),
        .stance_x_in  (stance_x_a),
        .stance_y_in  (stance_y_a),
        .side_out     (side_b),
        .weight       (weight),
        .lift         (lift),
        .stance_x_out (stance_x_b),
        .stance_y_out (stance_y_b)
    );

    // ------------------------------------------------------------------
    // Stages 7-8: scale the stride by w, round, clamp to +/-1.0 and pick
    // the swing or stance result into the output register.
    // ------------------------------------------------------------------
    gft_back u_back (
        .clk      (clk),
        .en       (stage_en[7:6]),
        .side     (side_b),
        .weight   (weight),
        .lift     (lift),
        .stance_x (stance_x_b),
        .stance_y (stance_y_b),
        .offset_x (offset.offset_x),
        .offset_y (offset.offset_y),
        .offset_z (offset.offset_z)
    );

endmodule

>>> sv/gft_pipe_ctrl.sv
module gft_pipe_ctrl #(
    parameter int STAGES = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              out_ready,
    output logic              in_ready,
    output logic              out_valid,
    output logic [STAGES-1:0] en
);

    logic [STAGES-1:0] valid_reg;
    logic [STAGES-1:0] valid_next;
    logic [STAGES:0]   ready;

    // A stage loads when it is empty or its successor moves on.
    always_comb
    begin
        ready[STAGES] = out_ready;
        for (int i = STAGES - 1; i >= 0; i--)
        begin
            ready[i] = !valid_reg[i] || ready[i+1];
        end
    end

    always_comb
    begin
        valid_next[0] = ready[0] ? in_valid : valid_reg[0];
        for (int i = 1; i < STAGES; i++)
        begin
            valid_next[i] = ready[i] ? valid_reg[i-1] : valid_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign en        = ready[STAGES-1:0];
    assign in_ready  = ready[0];
    assign out_valid = valid_reg[STAGES-1];

    a_empty_tail_takes: assert property (@(posedge clk) disable iff (!rst_n)
        !valid_reg[STAGES-1] |-> in_ready)
        else $error("pipe refuses input with an empty output stage");

    a_drain_frees_input: assert property (@(posedge clk) disable iff (!rst_n)
        out_ready |-> in_ready)
        else $error("pipe refuses input while the output drains");

    a_item_count: assert property (@(posedge clk) disable iff (!rst_n)
        rst_n |=> ($countones(valid_reg) == $past($countones(valid_reg))
                   + int'($past(in_valid && in_ready))
                   - int'($past(out_valid && out_ready))))
        else $error("items lost or duplicated in the pipe");

endmodule

>>> sv/gft_front.sv
module gft_front (
    input  logic                                 clk,
    input  logic [1:0]                           en,
    input  logic                                 in_swing,
    input  logic [gft_pkg::PROG_W-1:0]           progress,
    input  logic signed [gft_pkg::STRIDE_W-1:0]  span_x,
    input  logic signed [gft_pkg::STRIDE_W-1:0]  span_y,
    input  logic [gft_pkg::HEIGHT_W-1:0]         apex_height,
    output gft_pkg::gft_side_t                   side,
    output logic signed [gft_pkg::D_W-1:0]       dterm,
    output logic signed [gft_pkg::P_W-1:0]       pterm,
    output logic [gft_pkg::ZP_W-1:0]             zprod,
    output logic signed [gft_pkg::OFS_W-1:0]     stance_x,
    output logic signed [gft_pkg::OFS_W-1:0]     stance_y
);

    // Stage 1: clamp t, form u*t, t-u and the stance products
    logic [gft_pkg::PROG_W-1:0]           t;
    logic [gft_pkg::PROG_W-1:0]           u;
    logic [2*gft_pkg::PROG_W-1:0]         ut_full;
    logic signed [gft_pkg::V_W-1:0]       v_next;
    logic signed [gft_pkg::V_W-1:0]       k;
    logic signed [2*gft_pkg::STRIDE_W-1:0] kx_full;
    logic signed [2*gft_pkg::STRIDE_W-1:0] ky_full;

    gft_pkg::gft_side_t               side1_reg;
    logic [gft_pkg::UT_W-1:0]         ut_reg;
    logic signed [gft_pkg::V_W-1:0]   v_reg;
    logic signed [gft_pkg::KP_W-1:0]  kx_reg;
    logic signed [gft_pkg::KP_W-1:0]  ky_reg;

    always_comb
    begin
        t       = (progress > gft_pkg::ONE_Q16) ? gft_pkg::ONE_Q16 : progress;
        u       = gft_pkg::ONE_Q16 - t;
        ut_full = (2*gft_pkg::PROG_W)'(t) * (2*gft_pkg::PROG_W)'(u);
        v_next  = $signed({1'b0, t}) - $signed({1'b0, u});
        k       = $signed({1'b0, gft_pkg::HALF_Q16}) - $signed({1'b0, t});
        kx_full = (2*gft_pkg::STRIDE_W)'(span_x) * (2*gft_pkg::STRIDE_W)'(k);
        ky_full = (2*gft_pkg::STRIDE_W)'(span_y) * (2*gft_pkg::STRIDE_W)'(k);
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            side1_reg <= '{swing: in_swing, sx: span_x, sy: span_y};
            ut_reg    <= ut_full[gft_pkg::UT_W-1:0];
            v_reg     <= v_next;
            kx_reg    <= kx_full[gft_pkg::KP_W-1:0];
            ky_reg    <= ky_full[gft_pkg::KP_W-1:0];
        end
    end

    // Stage 2: t^3 - u^3 = (t - u)(2^32 - u*t), u*t*(t - u), lift product,
    // stance rounding
    logic [32:0]                       cu;
    logic signed [51:0]                d_full;
    logic signed [49:0]                p_full;
    logic [gft_pkg::ZP_W-1:0]          zp_next;
    logic signed [gft_pkg::KP_W-1:0]   kx_rnd;
    logic signed [gft_pkg::KP_W-1:0]   ky_rnd;

    gft_pkg::gft_side_t                side2_reg;
    logic signed [gft_pkg::D_W-1:0]    d_reg;
    logic signed [gft_pkg::P_W-1:0]    p_reg;
    logic [gft_pkg::ZP_W-1:0]          zp_reg;
    logic signed [gft_pkg::OFS_W-1:0]  stx_reg;
    logic signed [gft_pkg::OFS_W-1:0]  sty_reg;

    always_comb
    begin
        cu      = 33'h1_0000_0000 - {2'b00, ut_reg};
        d_full  = 52'($signed({1'b0, cu})) * 52'(v_reg);
        p_full  = 50'($signed({1'b0, ut_reg})) * 50'(v_reg);
        zp_next = (gft_pkg::ZP_W)'(apex_height) * (gft_pkg::ZP_W)'(ut_reg);
        kx_rnd  = kx_reg + $signed(34'd32768);
        ky_rnd  = ky_reg + $signed(34'd32768);
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            side2_reg <= side1_reg;
            d_reg     <= d_full[gft_pkg::D_W-1:0];
            p_reg     <= p_full[gft_pkg::P_W-1:0];
            zp_reg    <= zp_next;
            stx_reg   <= kx_rnd[33:16];
            sty_reg   <= ky_rnd[33:16];
        end
    end

    assign side     = side2_reg;
    assign dterm    = d_reg;
    assign pterm    = p_reg;
    assign zprod    = zp_reg;
    assign stance_x = stx_reg;
    assign stance_y = sty_reg;

endmodule

>>> sv/gft_weight.sv
module gft_weight (
    input  logic                                clk,
    input  logic [3:0]                          en,
    input  logic signed [gft_pkg::FRAC_W-1:0]   frac_offset,
    input  gft_pkg::gft_side_t                  side_in,
    input  logic signed [gft_pkg::D_W-1:0]      dterm,
    input  logic signed [gft_pkg::P_W-1:0]      pterm,
    input  logic [gft_pkg::ZP_W-1:0]            zprod,
    input  logic signed [gft_pkg::OFS_W-1:0]    stance_x_in,
    input  logic signed [gft_pkg::OFS_W-1:0]    stance_y_in,
    output gft_pkg::gft_side_t                  side_out,
    output logic signed [gft_pkg::W_W-1:0]      weight,
    output logic [gft_pkg::Z_W-1:0]             lift,
    output logic signed [gft_pkg::OFS_W-1:0]    stance_x_out,
    output logic signed [gft_pkg::OFS_W-1:0]    stance_y_out
);

    // Stage 3: g * P as two partial products, round the lift
    logic signed [41:0]                gpl_next;
    logic signed [40:0]                gph_next;
    logic [gft_pkg::ZP_W-1:0]          z_rnd;

    gft_pkg::gft_side_t                side3_reg;
    logic signed [41:0]                gpl_reg;
    logic signed [40:0]                gph_reg;
    logic signed [gft_pkg::D_W-1:0]    d3_reg;
    logic [gft_pkg::Z_W-1:0]           z3_reg;
    logic signed [gft_pkg::OFS_W-1:0]  stx3_reg;
    logic signed [gft_pkg::OFS_W-1:0]  sty3_reg;

    always_comb
    begin
        gpl_next = 42'(frac_offset) * 42'($signed({1'b0, pterm[23:0]}));
        gph_next = 41'(frac_offset) * 41'($signed(pterm[47:24]));
        z_rnd    = zprod + 47'h2000_0000;
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            side3_reg <= side_in;
            gpl_reg   <= gpl_next;
            gph_reg   <= gph_next;
            d3_reg    <= dterm;
            z3_reg    <= z_rnd[45:30];
            stx3_reg  <= stance_x_in;
            sty3_reg  <= stance_y_in;
        end
    end

    // Stage 4: merge partial products
    logic signed [63:0]                gp_next;

    gft_pkg::gft_side_t                side4_reg;
    logic signed [63:0]                gp_reg;
    logic signed [gft_pkg::D_W-1:0]    d4_reg;
    logic [gft_pkg::Z_W-1:0]           z4_reg;
    logic signed [gft_pkg::OFS_W-1:0]  stx4_reg;
    logic signed [gft_pkg::OFS_W-1:0]  sty4_reg;

    assign gp_next = (64'(gph_reg) <<< 24) + 64'(gpl_reg);

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            side4_reg <= side3_reg;
            gp_reg    <= gp_next;
            d4_reg    <= d3_reg;
            z4_reg    <= z3_reg;
            stx4_reg  <= stx3_reg;
            sty4_reg  <= sty3_reg;
        end
    end

    // Stage 5: round(g * E / 2^15) with E = -3 * P
    logic signed [65:0]                e_sum;

    gft_pkg::gft_side_t                side5_reg;
    logic signed [49:0]                r_reg;
    logic signed [gft_pkg::D_W-1:0]    d5_reg;
    logic [gft_pkg::Z_W-1:0]           z5_reg;
    logic signed [gft_pkg::OFS_W-1:0]  stx5_reg;
    logic signed [gft_pkg::OFS_W-1:0]  sty5_reg;

    assign e_sum = 66'sd16384 - 66'(gp_reg) - (66'(gp_reg) <<< 1);

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            side5_reg <= side4_reg;
            r_reg     <= e_sum[64:15];
            d5_reg    <= d4_reg;
            z5_reg    <= z4_reg;
            stx5_reg  <= stx4_reg;
            sty5_reg  <= sty4_reg;
        end
    end

    // Stage 6: N = D + r, weight = round(N / 2^17)
    logic signed [51:0]                n_rnd;

    gft_pkg::gft_side_t                side6_reg;
    logic signed [gft_pkg::W_W-1:0]    w_reg;
    logic [gft_pkg::Z_W-1:0]           z6_reg;
    logic signed [gft_pkg::OFS_W-1:0]  stx6_reg;
    logic signed [gft_pkg::OFS_W-1:0]  sty6_reg;

    assign n_rnd = 52'(d5_reg) + 52'(r_reg) + 52'sd65536;

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            side6_reg <= side5_reg;
            w_reg     <= n_rnd[49:17];
            z6_reg    <= z5_reg;
            stx6_reg  <= stx5_reg;
            sty6_reg  <= sty5_reg;
        end
    end

    assign side_out     = side6_reg;
    assign weight       = w_reg;
    assign lift         = z6_reg;
    assign stance_x_out = stx6_reg;
    assign stance_y_out = sty6_reg;

endmodule

>>> sv/gft_back.sv
module gft_back (
    input  logic                               clk,
    input  logic [1:0]                         en,
    input  gft_pkg::gft_side_t                 side,
    input  logic signed [gft_pkg::W_W-1:0]     weight,
    input  logic [gft_pkg::Z_W-1:0]            lift,
    input  logic signed [gft_pkg::OFS_W-1:0]   stance_x,
    input  logic signed [gft_pkg::OFS_W-1:0]   stance_y,
    output logic signed [gft_pkg::OFS_W-1:0]   offset_x,
    output logic signed [gft_pkg::OFS_W-1:0]   offset_y,
    output logic [gft_pkg::Z_W-1:0]            offset_z
);

    localparam int M_W = gft_pkg::STRIDE_W + gft_pkg::W_W;

    // Limit a Q1.16 result to [-1.0, +1.0]
    function automatic logic signed [gft_pkg::OFS_W-1:0] clamp_unit(
        input logic signed [gft_pkg::OFS_W:0] v
    );
        logic signed [gft_pkg::OFS_W:0] res;
        begin
            if (v > 19'sd65536)
                res = 19'sd65536;
            else if (v < -19'sd65536)
                res = -19'sd65536;
            else
                res = v;
            return res[gft_pkg::OFS_W-1:0];
        end
    endfunction

    // Stage 7: stride times Q0.32 weight
    logic signed [M_W-1:0]            mx_next;
    logic signed [M_W-1:0]            my_next;

    logic                             swing7_reg;
    logic signed [M_W-1:0]            mx_reg;
    logic signed [M_W-1:0]            my_reg;
    logic [gft_pkg::Z_W-1:0]          z7_reg;
    logic signed [gft_pkg::OFS_W-1:0] stx7_reg;
    logic signed [gft_pkg::OFS_W-1:0] sty7_reg;

    always_comb
    begin
        mx_next = M_W'(side.sx) * M_W'(weight);
        my_next = M_W'(side.sy) * M_W'(weight);
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            swing7_reg <= side.swing;
            mx_reg     <= mx_next;
            my_reg     <= my_next;
            z7_reg     <= lift;
            stx7_reg   <= stance_x;
            sty7_reg   <= stance_y;
        end
    end

    // Stage 8: round, clamp, pick phase; this is the output register
    logic signed [M_W-1:0]            rx;
    logic signed [M_W-1:0]            ry;
    logic signed [gft_pkg::OFS_W-1:0] ox_next;
    logic signed [gft_pkg::OFS_W-1:0] oy_next;
    logic [gft_pkg::Z_W-1:0]          oz_next;

    logic signed [gft_pkg::OFS_W-1:0] ox_reg;
    logic signed [gft_pkg::OFS_W-1:0] oy_reg;
    logic [gft_pkg::Z_W-1:0]          oz_reg;

    always_comb
    begin
        rx = mx_reg + $signed(M_W'(64'h8000_0000));
        ry = my_reg + $signed(M_W'(64'h8000_0000));
        if (swing7_reg)
        begin
            ox_next = clamp_unit(rx[M_W-1:32]);
            oy_next = clamp_unit(ry[M_W-1:32]);
            oz_next = z7_reg;
        end
        else
        begin
            ox_next = stx7_reg;
            oy_next = sty7_reg;
            oz_next = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            ox_reg <= ox_next;
            oy_reg <= oy_next;
            oz_reg <= oz_next;
        end
    end

    assign offset_x = ox_reg;
    assign offset_y = oy_reg;
    assign offset_z = oz_reg;

endmodule
